// ===== sv/tbk_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-background alpha key: shared definitions
// Register indexes, the configuration record, the item that travels from the
// classifying front end to the colour back end, and the pixel formats.
// ----------------------------------------------------------------------------
package tbk_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int GAIN_W     = 14;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 14;
    localparam int RECIP_W    = 16;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_BG_BLUE        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BG_GREEN       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BG_RED         = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_BLUE      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_GREEN     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_RED       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_ENABLE = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_MODE       = 3'd7;

    // Output formats
    typedef enum logic [1:0] {
        MODE_RGBA        = 2'd0,
        MODE_ALPHA_WHITE = 2'd1,
        MODE_RGB         = 2'd2,
        MODE_ALPHA_REP   = 2'd3
    } out_mode_t;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [PIX_W-1:0]         bg_blue;
        logic [PIX_W-1:0]         bg_green;
        logic [PIX_W-1:0]         bg_red;
        logic signed [GAIN_W-1:0] gain_blue;
        logic signed [GAIN_W-1:0] gain_green;
        logic signed [GAIN_W-1:0] gain_red;
        logic [2:0]               channel_enable;
        out_mode_t                out_mode;
    } cfg_t;

    // Input pixel pair, last field in the lowest bits
    typedef struct packed {
        logic [PIX_W-1:0] px2_red;
        logic [PIX_W-1:0] px2_green;
        logic [PIX_W-1:0] px2_blue;
        logic [PIX_W-1:0] px1_red;
        logic [PIX_W-1:0] px1_green;
        logic [PIX_W-1:0] px1_blue;
    } pix_t;

    // Output pixel, last field in the lowest bits
    typedef struct packed {
        logic [PIX_W-1:0] out_alpha;
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
    } res_t;

    // Classified item handed from the front end to the back end
    typedef struct packed {
        logic [PIX_W-1:0]   p1_blue;
        logic [PIX_W-1:0]   p1_green;
        logic [PIX_W-1:0]   p1_red;
        logic [PIX_W-1:0]   rev;
        logic [PIX_W-1:0]   alpha;
        logic [RECIP_W-1:0] recip;
        logic               keep;
    } job_t;

endpackage

// ===== sv/two_background_alpha_key.sv =====
// ----------------------------------------------------------------------------
// Two-background alpha key
// Recovers foreground colour and alpha of a pixel shot over two known
// backgrounds, with four output formats.
//
// Channel   Direction  Ports                         Payload
// input     slave      s_tvalid s_tready s_tdata     two BGR pixels, 48 bits
// result    master     m_tvalid m_tready m_tdata     BGRA pixel, 32 bits
// config    write      cfg_we cfg_addr cfg_wdata     eight registers
//
// One pixel pair per clock is sustained while m_tready stays high; the multipliers are fully pipelined.
// An input transfer loads front stage A, then stage B, the queue, stage C and
// the output register, which drives m_tvalid.
// aresetn is synchronous; it empties the pipeline and clears the registers.
// A stall at m_tready fills the back stages, then the queue, then the two
// front stages, and only then drops s_tready.
// ----------------------------------------------------------------------------
module two_background_alpha_key #(
    parameter int QUEUE_DEPTH = tbk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // px1_blue, px1_green, px1_red, px2_blue, px2_green, px2_red
    input  logic [47:0]                      s_tdata,
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_blue, out_green, out_red, out_alpha
    output logic [31:0]                      m_tdata,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [tbk_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tbk_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    tbk_pkg::cfg_t cfg_reg;
    tbk_pkg::pix_t s_pix;
    tbk_pkg::res_t m_res;
    tbk_pkg::job_t f_job;
    tbk_pkg::job_t q_job;
    logic          f_valid;
    logic          f_ready;
    logic          q_valid;
    logic          q_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                tbk_pkg::REG_BG_BLUE:        cfg_reg.bg_blue    <= cfg_wdata[7:0];
                tbk_pkg::REG_BG_GREEN:       cfg_reg.bg_green   <= cfg_wdata[7:0];
                tbk_pkg::REG_BG_RED:         cfg_reg.bg_red     <= cfg_wdata[7:0];
                tbk_pkg::REG_GAIN_BLUE:      cfg_reg.gain_blue  <= cfg_wdata;
                tbk_pkg::REG_GAIN_GREEN:     cfg_reg.gain_green <= cfg_wdata;
                tbk_pkg::REG_GAIN_RED:       cfg_reg.gain_red   <= cfg_wdata;
                tbk_pkg::REG_CHANNEL_ENABLE: cfg_reg.channel_enable <= cfg_wdata[2:0];
                tbk_pkg::REG_OUT_MODE: begin
                    cfg_reg.out_mode <= tbk_pkg::out_mode_t'(cfg_wdata[1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    assign s_pix   = tbk_pkg::pix_t'(s_tdata);
    assign m_tdata = m_res;

    // Front end: differences, inverse alpha, reciprocal
    tbk_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (s_pix),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_job   (f_job)
    );

    // Queue between the two halves
    tbk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_job   (f_job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_job   (q_job)
    );

    // Back end: colour recovery and formatting
    tbk_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_job    (q_job),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (m_res)
    );

    // The 24-bit formats never carry alpha.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (cfg_reg.out_mode == tbk_pkg::MODE_RGB ||
                     cfg_reg.out_mode == tbk_pkg::MODE_ALPHA_REP)
        |-> m_res.out_alpha == 8'd0)
        else $error("alpha byte set in a 24-bit format");

    // With no channel enabled alpha is zero, so RGBA results are all zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cfg_reg.channel_enable == 3'd0 &&
        cfg_reg.out_mode == tbk_pkg::MODE_RGBA
        |-> m_tdata == 32'd0)
        else $error("nonzero result with all channels disabled");

    // Alpha-with-white format always shows white colour.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cfg_reg.out_mode == tbk_pkg::MODE_ALPHA_WHITE
        |-> m_tdata[23:0] == 24'hffffff)
        else $error("colour not white in alpha-with-white format");

    // Reset empties the output stage.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

// ===== sv/tbk_front.sv =====
// ----------------------------------------------------------------------------
// Two-background alpha key: front end
// Accepts pixel pairs, forms the scaled background differences, takes their
// minimum as inverse alpha and looks up the alpha reciprocal.
// ----------------------------------------------------------------------------
module tbk_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  tbk_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  tbk_pkg::pix_t in_pix,
    output logic          out_valid,
    input  logic          out_ready,
    output tbk_pkg::job_t out_job
);

    localparam int DIFF_W = tbk_pkg::PIX_W + 1;
    localparam int PROD_W = DIFF_W + tbk_pkg::GAIN_W;
    localparam int T_W    = PROD_W - 9;

    // Reciprocal table: 0x10100 / alpha, zero where alpha is below two.
    logic [tbk_pkg::RECIP_W-1:0] recip_tab [256];
    for (genvar Alpha = 0; Alpha < 256; Alpha++) begin : g_recip
        localparam int Divisor  = (Alpha < 2) ? 1 : Alpha;
        localparam int RecipVal = (Alpha < 2) ? 0 : 32'h10100 / Divisor;
        assign recip_tab[Alpha] = tbk_pkg::RECIP_W'(RecipVal);
    end

    // Lane views, blue at index 0
    logic [tbk_pkg::PIX_W-1:0]  p1 [3];
    logic [tbk_pkg::PIX_W-1:0]  p2 [3];
    logic [tbk_pkg::GAIN_W-1:0] gain [3];

    assign p1[0]   = in_pix.px1_blue;
    assign p1[1]   = in_pix.px1_green;
    assign p1[2]   = in_pix.px1_red;
    assign p2[0]   = in_pix.px2_blue;
    assign p2[1]   = in_pix.px2_green;
    assign p2[2]   = in_pix.px2_red;
    assign gain[0] = cfg.gain_blue;
    assign gain[1] = cfg.gain_green;
    assign gain[2] = cfg.gain_red;

    // Stage registers
    logic                      a_valid_reg;
    logic signed [PROD_W-1:0]  a_prod_reg [3];
    logic signed [PROD_W-1:0]  a_prod_next [3];
    logic [tbk_pkg::PIX_W-1:0] a_p1_reg [3];
    logic                      b_valid_reg;
    tbk_pkg::job_t             b_job_reg;
    tbk_pkg::job_t             b_job_next;

    logic a_adv;
    logic b_adv;

    // Stall chain: a stage moves when it is empty or its successor moves.
    assign b_adv    = !b_valid_reg || out_ready;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_ready = a_adv;

    // Stage A: signed difference times gain, one multiplier per lane.
    always_comb begin
        logic signed [DIFF_W-1:0] diff;
        for (int c = 0; c < 3; c++) begin
            diff = $signed({1'b0, p1[c]}) - $signed({1'b0, p2[c]});
            a_prod_next[c] = PROD_W'(diff * $signed(gain[c]));
        end
    end

    // Stage B: floor shift, minimum over enabled lanes, clamp, table lookup.
    always_comb begin
        logic signed [T_W-1:0] t;
        logic signed [T_W-1:0] cur;
        cur = T_W'(255);
        for (int c = 0; c < 3; c++) begin
            t = T_W'(a_prod_reg[c] >>> 9);
            if (cfg.channel_enable[c] && (t < cur)) begin
                cur = t;
            end
        end
        b_job_next          = '0;
        b_job_next.p1_blue  = a_p1_reg[0];
        b_job_next.p1_green = a_p1_reg[1];
        b_job_next.p1_red   = a_p1_reg[2];
        b_job_next.rev      = cur[T_W-1] ? '0 : cur[tbk_pkg::PIX_W-1:0];
        b_job_next.alpha    = 8'd255 - b_job_next.rev;
        b_job_next.keep     = (b_job_next.alpha >= 8'd2);
        b_job_next.recip    = recip_tab[b_job_next.alpha];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_adv) begin
                a_valid_reg <= in_valid;
            end
            if (b_adv) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (a_adv && in_valid) begin
            for (int c = 0; c < 3; c++) begin
                a_prod_reg[c] <= a_prod_next[c];
                a_p1_reg[c]   <= p1[c];
            end
        end
        if (b_adv && a_valid_reg) begin
            b_job_reg <= b_job_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_job   = b_job_reg;

endmodule

// ===== sv/tbk_queue.sv =====
// ----------------------------------------------------------------------------
// Two-background alpha key: job queue
// Short first-in first-out buffer that lets the front end and the back end
// stall independently.
// ----------------------------------------------------------------------------
module tbk_queue #(
    parameter int DEPTH = tbk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  tbk_pkg::job_t wr_job,
    output logic          rd_valid,
    input  logic          rd_ready,
    output tbk_pkg::job_t rd_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tbk_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== sv/tbk_back.sv =====
// ----------------------------------------------------------------------------
// Two-background alpha key: back end
// Removes background 1, divides by alpha through the reciprocal, clips and
// formats the result into the output register.
// ----------------------------------------------------------------------------
module tbk_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  tbk_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  tbk_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output tbk_pkg::res_t out_res
);

    localparam int VAL_W = 2 * tbk_pkg::PIX_W;
    localparam int MUL_W = VAL_W + tbk_pkg::RECIP_W;

    logic [tbk_pkg::PIX_W-1:0] p1 [3];
    logic [tbk_pkg::PIX_W-1:0] bg [3];

    assign p1[0] = in_job.p1_blue;
    assign p1[1] = in_job.p1_green;
    assign p1[2] = in_job.p1_red;
    assign bg[0] = cfg.bg_blue;
    assign bg[1] = cfg.bg_green;
    assign bg[2] = cfg.bg_red;

    // Stage registers
    logic                        c_valid_reg;
    logic [VAL_W-1:0]            c_val_reg [3];
    logic [VAL_W-1:0]            c_val_next [3];
    logic [tbk_pkg::RECIP_W-1:0] c_recip_reg;
    logic [tbk_pkg::PIX_W-1:0]   c_alpha_reg;
    logic                        c_keep_reg;
    logic                        out_valid_reg;
    tbk_pkg::res_t               out_res_reg;
    tbk_pkg::res_t               out_res_next;

    logic c_adv;
    logic d_adv;

    assign d_adv    = !out_valid_reg || out_ready;
    assign c_adv    = !c_valid_reg || d_adv;
    assign in_ready = c_adv;

    // Stage C: 255 * px1 minus background times inverse alpha, floored at zero.
    always_comb begin
        logic [VAL_W-1:0] pos;
        logic [VAL_W-1:0] neg;
        logic [VAL_W:0]   v;
        for (int c = 0; c < 3; c++) begin
            pos = {p1[c], 8'd0} - {8'd0, p1[c]};
            neg = VAL_W'(bg[c] * in_job.rev);
            v   = {1'b0, pos} - {1'b0, neg};
            c_val_next[c] = v[VAL_W] ? '0 : v[VAL_W-1:0];
        end
    end

    // Stage D: multiply by the reciprocal, keep the upper half, clip, format.
    always_comb begin
        logic [MUL_W-1:0]          prod;
        logic [VAL_W-1:0]          q;
        logic [tbk_pkg::PIX_W-1:0] col [3];
        logic [tbk_pkg::PIX_W-1:0] ca;
        for (int c = 0; c < 3; c++) begin
            prod = MUL_W'(c_val_reg[c] * c_recip_reg);
            q    = prod[MUL_W-1 -: VAL_W];
            if (!c_keep_reg) begin
                col[c] = '0;
            end else if (|q[VAL_W-1:tbk_pkg::PIX_W]) begin
                col[c] = 8'hff;
            end else begin
                col[c] = q[tbk_pkg::PIX_W-1:0];
            end
        end
        ca = c_keep_reg ? c_alpha_reg : '0;
        unique case (cfg.out_mode)
            tbk_pkg::MODE_RGBA: begin
                out_res_next = '{out_alpha: ca, out_red: col[2],
                                 out_green: col[1], out_blue: col[0]};
            end
            tbk_pkg::MODE_ALPHA_WHITE: begin
                out_res_next = '{out_alpha: ca, out_red: 8'hff,
                                 out_green: 8'hff, out_blue: 8'hff};
            end
            tbk_pkg::MODE_RGB: begin
                out_res_next = '{out_alpha: 8'd0, out_red: col[2],
                                 out_green: col[1], out_blue: col[0]};
            end
            default: begin
                out_res_next = '{out_alpha: 8'd0, out_red: ca,
                                 out_green: ca, out_blue: ca};
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (c_adv) begin
                c_valid_reg <= in_valid;
            end
            if (d_adv) begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (c_adv && in_valid) begin
            for (int c = 0; c < 3; c++) begin
                c_val_reg[c] <= c_val_next[c];
            end
            c_recip_reg <= in_job.recip;
            c_alpha_reg <= in_job.alpha;
            c_keep_reg  <= in_job.keep;
        end
        if (d_adv && c_valid_reg) begin
            out_res_reg <= out_res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// ===== dv/tb_two_background_alpha_key.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-background alpha key: self-checking testbench
// Drives pixel pairs into the key, predicts the output pixels from its own
// model of the inverse-alpha minimum, the unmixing and the output formats,
// and compares each result field by field. A short directed table covers the
// register extremes, alpha below two, disabled channels and every output
// format. Random phases then follow with both physically consistent pixel
// pairs and noise. Backpressure, idle gaps and register changes between
// phases are part of the run.
// ----------------------------------------------------------------------------
module tb_two_background_alpha_key;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int N_PHASES        = 10;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int RX_HOLD_CYCLES  = 80;
    localparam int SETTLE_CYCLES   = 12;

    // One row of the directed table. Rows with want_typed carry their own
    // expected pixel; the others are checked against the predictor.
    typedef struct packed {
        tbk_pkg::cfg_t cfg;
        tbk_pkg::pix_t px;
        bit            want_typed;
        tbk_pkg::res_t want;
    } dir_row_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [47:0]                    s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [31:0]                    m_tdata;
    logic                           cfg_we    = 1'b0;
    logic [tbk_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [tbk_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Register copy used for prediction, and the pixels still owed by the key.
    tbk_pkg::cfg_t cur_cfg = '0;
    tbk_pkg::res_t pixel_exp[$];

    int hold_reqs  = 0;
    int hold_seen  = 0;
    int rx_hold    = 0;
    bit rx_no_idle = 1'b0;
    bit tx_no_idle = 1'b0;
    int n_items    = 0;
    int n_directed = 0;
    int n_results  = 0;
    int n_fail     = 0;
    int n_settings = 0;
    int cycle_cnt  = 0;

    two_background_alpha_key uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Builders for pixels, results and register sets
    // ------------------------------------------------------------------------
    function automatic tbk_pkg::pix_t mk_px(logic [7:0] b1, logic [7:0] g1,
                                            logic [7:0] r1, logic [7:0] b2,
                                            logic [7:0] g2, logic [7:0] r2);
        tbk_pkg::pix_t p;
        p.px1_blue  = b1;
        p.px1_green = g1;
        p.px1_red   = r1;
        p.px2_blue  = b2;
        p.px2_green = g2;
        p.px2_red   = r2;
        return p;
    endfunction

    function automatic tbk_pkg::res_t mk_res(logic [7:0] b, logic [7:0] g,
                                             logic [7:0] r, logic [7:0] a);
        tbk_pkg::res_t o;
        o.out_blue  = b;
        o.out_green = g;
        o.out_red   = r;
        o.out_alpha = a;
        return o;
    endfunction

    function automatic tbk_pkg::cfg_t mk_cfg(logic [7:0] bgb, logic [7:0] bgg,
                                             logic [7:0] bgr,
                                             logic [tbk_pkg::GAIN_W-1:0] gb,
                                             logic [tbk_pkg::GAIN_W-1:0] gg,
                                             logic [tbk_pkg::GAIN_W-1:0] gr,
                                             logic [2:0] en,
                                             tbk_pkg::out_mode_t mode);
        tbk_pkg::cfg_t c;
        c.bg_blue        = bgb;
        c.bg_green       = bgg;
        c.bg_red         = bgr;
        c.gain_blue      = gb;
        c.gain_green     = gg;
        c.gain_red       = gr;
        c.channel_enable = en;
        c.out_mode       = mode;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // Inverse-alpha estimate of one channel: floor((px1 - px2) * 128 * gain / 2^16).
    function automatic longint chan_inv_alpha(logic [7:0] a, logic [7:0] b,
                                              logic signed [tbk_pkg::GAIN_W-1:0] g);
        longint d;
        d = longint'(a) - longint'(b);
        return (d * 128 * longint'(g)) >>> 16;
    endfunction

    // Removes background 1 from a channel and divides by alpha.
    function automatic logic [7:0] unmix(logic [7:0] px, logic [7:0] bg,
                                         longint inv_a, longint recip);
        longint v;
        v = longint'(px) * 255 - longint'(bg) * inv_a;
        if (v < 0) v = 0;
        v = (v * recip) >>> 16;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic tbk_pkg::res_t predict_key(tbk_pkg::cfg_t c, tbk_pkg::pix_t p);
        longint        inv_a;
        longint        t;
        longint        alpha;
        longint        recip;
        logic [7:0]    cb;
        logic [7:0]    cg;
        logic [7:0]    cr;
        logic [7:0]    ca;
        tbk_pkg::res_t o;
        inv_a = 255;
        cb = '0;
        cg = '0;
        cr = '0;
        ca = '0;
        if (c.channel_enable[0]) begin
            t = chan_inv_alpha(p.px1_blue, p.px2_blue, c.gain_blue);
            if (t < inv_a) inv_a = t;
        end
        if (c.channel_enable[1]) begin
            t = chan_inv_alpha(p.px1_green, p.px2_green, c.gain_green);
            if (t < inv_a) inv_a = t;
        end
        if (c.channel_enable[2]) begin
            t = chan_inv_alpha(p.px1_red, p.px2_red, c.gain_red);
            if (t < inv_a) inv_a = t;
        end
        if (inv_a < 0) inv_a = 0;
        alpha = 255 - inv_a;

        // Colour is only recovered when alpha is at least two.
        if (alpha >= 2) begin
            recip = 64'sh10100 / alpha;
            cb = unmix(p.px1_blue,  c.bg_blue,  inv_a, recip);
            cg = unmix(p.px1_green, c.bg_green, inv_a, recip);
            cr = unmix(p.px1_red,   c.bg_red,   inv_a, recip);
            ca = alpha[7:0];
        end

        case (c.out_mode)
            tbk_pkg::MODE_RGBA:        o = mk_res(cb, cg, cr, ca);
            tbk_pkg::MODE_ALPHA_WHITE: o = mk_res(8'd255, 8'd255, 8'd255, ca);
            tbk_pkg::MODE_RGB:         o = mk_res(cb, cg, cr, 8'd0);
            default:                   o = mk_res(ca, ca, ca, 8'd0);
        endcase
        return o;
    endfunction

    // Pixel of a foreground f with alpha a over background bg, with a little noise.
    function automatic logic [7:0] blend(int a, int f, int bg);
        int v;
        v = (a * f + (255 - a) * bg) / 255 + int'($urandom_range(4)) - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // ------------------------------------------------------------------------
    // Input side and register port
    // ------------------------------------------------------------------------
    // Offers one pixel pair, waits for its transfer and records what it owes.
    task automatic send_pair(tbk_pkg::pix_t p, bit want_typed, tbk_pkg::res_t want);
        int gap;
        gap = (tx_no_idle || $urandom_range(99) >= 20) ? 0 : $urandom_range(1, 2);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (s_tready !== 1'b1);
        pixel_exp.push_back(want_typed ? want : predict_key(cur_cfg, p));
        n_items++;
    endtask

    // Stops offering and waits until every owed pixel has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pixel_exp.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [tbk_pkg::CFG_ADDR_W-1:0] idx,
                             logic [tbk_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic apply_cfg(tbk_pkg::cfg_t c);
        write_reg(tbk_pkg::REG_BG_BLUE,        tbk_pkg::CFG_DATA_W'(c.bg_blue));
        write_reg(tbk_pkg::REG_BG_GREEN,       tbk_pkg::CFG_DATA_W'(c.bg_green));
        write_reg(tbk_pkg::REG_BG_RED,         tbk_pkg::CFG_DATA_W'(c.bg_red));
        write_reg(tbk_pkg::REG_GAIN_BLUE,      c.gain_blue);
        write_reg(tbk_pkg::REG_GAIN_GREEN,     c.gain_green);
        write_reg(tbk_pkg::REG_GAIN_RED,       c.gain_red);
        write_reg(tbk_pkg::REG_CHANNEL_ENABLE, tbk_pkg::CFG_DATA_W'(c.channel_enable));
        write_reg(tbk_pkg::REG_OUT_MODE,       tbk_pkg::CFG_DATA_W'(c.out_mode));
        cfg_we  <= 1'b0;
        cur_cfg = c;
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random backpressure, with a long hold on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            rx_hold   = RX_HOLD_CYCLES;
        end
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else begin
            m_tready <= rx_no_idle || ($urandom_range(99) >= 20);
        end
    end

    // Each result transfer is compared with the oldest owed pixel.
    always @(posedge aclk) begin : result_check
        tbk_pkg::res_t got;
        tbk_pkg::res_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got = tbk_pkg::res_t'(m_tdata);
            if (pixel_exp.size() == 0) begin
                $error("result 0x%08h arrived with nothing owed", m_tdata);
                n_fail++;
            end else begin
                want = pixel_exp.pop_front();
                n_results++;
                if (got.out_blue !== want.out_blue) begin
                    $error("out_blue expected %0d got %0d", want.out_blue, got.out_blue);
                    n_fail++;
                end
                if (got.out_green !== want.out_green) begin
                    $error("out_green expected %0d got %0d", want.out_green, got.out_green);
                    n_fail++;
                end
                if (got.out_red !== want.out_red) begin
                    $error("out_red expected %0d got %0d", want.out_red, got.out_red);
                    n_fail++;
                end
                if (got.out_alpha !== want.out_alpha) begin
                    $error("out_alpha expected %0d got %0d", want.out_alpha, got.out_alpha);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_two_background_alpha_key: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : main_seq
        dir_row_t                   rows[$];
        tbk_pkg::cfg_t              c_reset;
        tbk_pkg::cfg_t              c_white;
        tbk_pkg::cfg_t              c_unit;
        tbk_pkg::cfg_t              c_rep;
        tbk_pkg::cfg_t              c_rgb;
        tbk_pkg::cfg_t              c_neg;
        tbk_pkg::cfg_t              c_gmax;
        tbk_pkg::cfg_t              c_gmin;
        tbk_pkg::cfg_t              c_mix;
        tbk_pkg::cfg_t              rc;
        tbk_pkg::pix_t              p;
        int                         bg1[3];
        int                         bg2[3];
        int                         q1[3];
        int                         q2[3];
        logic [tbk_pkg::GAIN_W-1:0] gsel[3];
        logic [2:0]                 en;
        int                         kind;
        int                         a;
        int                         f;
        int                         r;
        int                         g;

        c_reset = '0;
        // A gain of 512 makes each channel's inverse alpha equal to px1 - px2.
        c_white = mk_cfg(100, 100, 100, 512, 512, 512, 3'b000, tbk_pkg::MODE_ALPHA_WHITE);
        c_unit  = mk_cfg(0, 0, 0, 512, 512, 512, 3'b111, tbk_pkg::MODE_RGBA);
        c_rep   = mk_cfg(0, 0, 0, 512, 512, 512, 3'b111, tbk_pkg::MODE_ALPHA_REP);
        c_rgb   = mk_cfg(255, 255, 255, 512, 512, 512, 3'b111, tbk_pkg::MODE_RGB);
        c_neg   = mk_cfg(255, 255, 255, 1024, 1024, 1024, 3'b111, tbk_pkg::MODE_RGBA);
        c_gmax  = mk_cfg(0, 0, 0, 14'h1FFF, 14'h1FFF, 14'h1FFF, 3'b111,
                         tbk_pkg::MODE_RGBA);
        c_gmin  = mk_cfg(255, 255, 255, 14'h2000, 14'h2000, 14'h2000, 3'b111,
                         tbk_pkg::MODE_ALPHA_WHITE);
        c_mix   = mk_cfg(10, 20, 30, 512, 14'h3000, 512, 3'b101, tbk_pkg::MODE_RGBA);

        // Registers straight out of reset: nothing enabled, all zero.
        rows.push_back('{c_reset, mk_px(255, 255, 255, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0)});
        rows.push_back('{c_reset, mk_px(0, 0, 0, 255, 255, 255), 1'b1, mk_res(0, 0, 0, 0)});
        // No channel enabled: alpha is zero and the white format still applies.
        rows.push_back('{c_white, mk_px(77, 140, 3, 200, 9, 250), 1'b1,
                         mk_res(255, 255, 255, 0)});
        // Opaque pixel, alpha one, alpha two, one dominant channel, equal pixels.
        rows.push_back('{c_unit, mk_px(0, 0, 0, 255, 255, 255), 1'b1, mk_res(0, 0, 0, 255)});
        rows.push_back('{c_unit, mk_px(254, 254, 254, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0)});
        rows.push_back('{c_unit, mk_px(253, 253, 253, 0, 0, 0), 1'b0, tbk_pkg::res_t'('0)});
        rows.push_back('{c_unit, mk_px(255, 10, 255, 0, 0, 0), 1'b0, tbk_pkg::res_t'('0)});
        rows.push_back('{c_unit, mk_px(128, 128, 128, 128, 128, 128), 1'b0,
                         tbk_pkg::res_t'('0)});
        // Alpha replicated into rgb; out_alpha stays zero.
        rows.push_back('{c_rep, mk_px(0, 0, 0, 255, 255, 255), 1'b1,
                         mk_res(255, 255, 255, 0)});
        rows.push_back('{c_rep, mk_px(254, 254, 254, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0)});
        rows.push_back('{c_rep, mk_px(90, 60, 200, 30, 20, 10), 1'b0, tbk_pkg::res_t'('0)});
        // Rgb only; a colour that would go negative is clipped to zero.
        rows.push_back('{c_rgb, mk_px(254, 254, 254, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0)});
        rows.push_back('{c_rgb, mk_px(200, 200, 200, 100, 100, 100), 1'b0,
                         tbk_pkg::res_t'('0)});
        rows.push_back('{c_neg, mk_px(100, 100, 100, 0, 0, 0), 1'b0, tbk_pkg::res_t'('0)});
        // Gains at the raw 14-bit extremes.
        rows.push_back('{c_gmax, mk_px(1, 1, 1, 0, 0, 0), 1'b0, tbk_pkg::res_t'('0)});
        rows.push_back('{c_gmax, mk_px(0, 0, 0, 1, 1, 1), 1'b1, mk_res(0, 0, 0, 255)});
        rows.push_back('{c_gmin, mk_px(0, 0, 0, 255, 255, 255), 1'b1,
                         mk_res(255, 255, 255, 0)});
        rows.push_back('{c_gmin, mk_px(255, 255, 255, 0, 0, 0), 1'b1,
                         mk_res(255, 255, 255, 255)});
        rows.push_back('{c_gmin, mk_px(255, 255, 255, 254, 254, 254), 1'b1,
                         mk_res(255, 255, 255, 255)});
        // Green disabled, with a negative gain on it.
        rows.push_back('{c_mix, mk_px(200, 0, 150, 50, 255, 100), 1'b0, tbk_pkg::res_t'('0)});
        rows.push_back('{c_mix, mk_px(255, 255, 255, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0)});

        // Hold reset, then release it.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table; registers only change while the key is empty.
        foreach (rows[i]) begin
            if (rows[i].cfg != cur_cfg) begin
                settle();
                apply_cfg(rows[i].cfg);
            end
            send_pair(rows[i].px, rows[i].want_typed, rows[i].want);
        end
        n_directed = n_items;

        // Random phases, each with its own register set and output format.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            kind = ph % 5;
            en   = '0;
            for (int ch = 0; ch < 3; ch++) begin
                bg1[ch] = $urandom_range(255);
                if (kind == 2) begin
                    // Arbitrary gains and enables.
                    bg2[ch]  = $urandom_range(255);
                    gsel[ch] = tbk_pkg::GAIN_W'($urandom_range(16383));
                    en[ch]   = 1'($urandom_range(1));
                end else if (kind == 3) begin
                    // Backgrounds at their extremes, gains from a fixed set including both extremes.
                    bg1[ch] = $urandom_range(1) ? 255 : 0;
                    bg2[ch] = 255 - bg1[ch];
                    case ($urandom_range(4))
                        0:       gsel[ch] = 14'h1FFF;
                        1:       gsel[ch] = 14'h2000;
                        2:       gsel[ch] = 14'h1000;
                        3:       gsel[ch] = 14'h3000;
                        default: gsel[ch] = '0;
                    endcase
                    en[ch] = 1'($urandom_range(1));
                end else if ($urandom_range(3) == 0) begin
                    // Backgrounds too close together: channel left out.
                    bg2[ch]  = (bg1[ch] >= 128) ? bg1[ch] - int'($urandom_range(31))
                                                : bg1[ch] + int'($urandom_range(31));
                    gsel[ch] = tbk_pkg::GAIN_W'($urandom_range(16383));
                end else begin
                    // Usable background pair with the gain software would compute.
                    do bg2[ch] = $urandom_range(255);
                    while (bg1[ch] - bg2[ch] < 32 && bg1[ch] - bg2[ch] > -32);
                    g        = 32'sh20000 / (bg1[ch] - bg2[ch]);
                    gsel[ch] = g[tbk_pkg::GAIN_W-1:0];
                    en[ch]   = 1'b1;
                end
            end
            rc = mk_cfg(8'(bg1[0]), 8'(bg1[1]), 8'(bg1[2]), gsel[0], gsel[1], gsel[2],
                        en, tbk_pkg::out_mode_t'((ph * 3) % 4));
            settle();
            apply_cfg(rc);

            // One phase meets a long receiver hold with back-to-back input;
            // another runs with no idling on either side.
            tx_no_idle = (ph == 3) || (ph == 5);
            rx_no_idle = (ph == 5);
            if (ph == 3) hold_reqs++;

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                r = $urandom_range(99);
                if (kind != 2 && kind != 3 && r < 75) begin
                    // Consistent shot of one foreground over both backgrounds.
                    a = $urandom_range(99);
                    a = (a < 20) ? 0 : (a < 30) ? 255 : $urandom_range(255);
                    for (int ch = 0; ch < 3; ch++) begin
                        f      = $urandom_range(255);
                        q1[ch] = int'(blend(a, f, bg1[ch]));
                        q2[ch] = int'(blend(a, f, bg2[ch]));
                    end
                end else begin
                    // Noise: fully random, or a second pixel close to the first.
                    for (int ch = 0; ch < 3; ch++) begin
                        q1[ch] = $urandom_range(255);
                        if (r % 2 == 0) begin
                            q2[ch] = $urandom_range(255);
                        end else begin
                            q2[ch] = q1[ch] + int'($urandom_range(40)) - 20;
                            if (q2[ch] < 0) q2[ch] = 0;
                            if (q2[ch] > 255) q2[ch] = 255;
                        end
                    end
                end
                p = mk_px(8'(q1[0]), 8'(q1[1]), 8'(q1[2]), 8'(q2[0]), 8'(q2[1]), 8'(q2[2]));
                send_pair(p, 1'b0, tbk_pkg::res_t'('0));
                // Halfway through one phase the sender waits for the key to empty.
                if (ph == 6 && k == ITEMS_PER_PHASE / 2) settle();
            end
        end

        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        settle();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d pixel pairs (%0d from the directed table), %0d results.",
                 n_items, n_directed, n_results);
        $display("Register sets: %0d, all four formats, a long output stall and pauses.",
                 n_settings);
        if (n_fail == 0 && pixel_exp.size() == 0) begin
            $display("tb_two_background_alpha_key: PASS");
        end else begin
            $display("tb_two_background_alpha_key: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tbk_pkg.sv
sv/tbk_front.sv
sv/tbk_queue.sv
sv/tbk_back.sv
sv/two_background_alpha_key.sv
dv/tb_two_background_alpha_key.sv
